[rtl/wzfs_pkg.sv]
package wzfs_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned IdBitsDef   = 8;
  localparam int unsigned MinCycle    = 2;
  localparam int unsigned CoordW      = 16;

  typedef enum logic [2:0] {
    MODE_ADD      = 3'd0,
    MODE_REMOVE   = 3'd1,
    MODE_SETVIS   = 3'd2,
    MODE_FOCUS_ID = 3'd3,
    MODE_POINT    = 3'd4,
    MODE_NEXT     = 3'd5,
    MODE_PREV     = 3'd6,
    MODE_QUERY    = 3'd7
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_FX_RD,
    S_FX_EV,
    S_SH_RD,
    S_SH_WR,
    S_HOLD_WR,
    S_RESP
  } state_e;

  typedef enum logic [2:0] {
    K_FIND_CMD,
    K_FIND_FOC,
    K_TOPVIS,
    K_POINT,
    K_CAND
  } kind_e;

  typedef struct packed {
    logic       ok;
    logic       active_valid;
    logic [7:0] active_id;
    logic [6:0] window_count;
  } resp_t;

endpackage

[rtl/wzfs_mem.sv]
module wzfs_mem
  import wzfs_pkg::*;
#(
  parameter int unsigned Depth = CapacityDef,
  parameter int unsigned Width = IdBitsDef + 65,
  parameter int unsigned AW    = $clog2(CapacityDef)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/wzfs_ctrl.sv]
module wzfs_ctrl
  import wzfs_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef,
  parameter int unsigned ID_BITS  = IdBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  window_id_i,
  input  logic        normal_class_i,
  input  logic        visible_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] width_i,
  input  logic [15:0] height_i,
  output logic        resp_valid_o,
  input  logic        resp_ready_i,
  output resp_t       resp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = ID_BITS + 1;
  localparam int unsigned EW = KW + 4 * CoordW;

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;
  mode_e  mode_q, mode_d;
  logic [ID_BITS-1:0] cid_q, cid_d, fid_q, fid_d;
  logic               vis_q, vis_d, fv_q, fv_d, up_q, up_d, ok_q, ok_d;
  logic signed [CoordW-1:0] px_q, px_d, py_q, py_d;
  logic [CW-1:0] count_q, count_d, left_q, left_d, idx_q, idx_d, a_q, a_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [EW-1:0] hold_q, hold_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  wzfs_mem #(.Depth(CAPACITY), .Width(EW), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic                     accept;
  mode_e                    in_mode;
  logic [ID_BITS-1:0]       in_id;
  logic [ID_BITS-1:0]       rk_id;
  logic                     rk_vis;
  logic signed [CoordW-1:0] rl, rt;
  logic [CoordW-1:0]        rw, rh;
  logic signed [CoordW+1:0] xr, yb, xs, ys, ls, ts;
  logic                     inside_pt, hit, fx_bad, fx_reject, sh_more;
  logic                     refocus_rm, refocus_sv, cand_fwd;
  logic [AW-1:0]            cnt_m1, ptr_step, cand_ptr;
  logic [CW-1:0]            a_src;
  logic [CW:0]              ptr_nx;

  assign accept  = in_valid_i && (state_q == S_IDLE);
  assign in_mode = mode_e'(mode_i);
  assign in_id   = ID_BITS'(window_id_i);

  assign rk_id  = rdata[ID_BITS-1:0];
  assign rk_vis = rdata[ID_BITS];
  assign rl     = $signed(rdata[KW+CoordW-1:KW]);
  assign rt     = $signed(rdata[KW+2*CoordW-1:KW+CoordW]);
  assign rw     = rdata[KW+3*CoordW-1:KW+2*CoordW];
  assign rh     = rdata[KW+4*CoordW-1:KW+3*CoordW];
  assign ls     = (CoordW+2)'(rl);
  assign ts     = (CoordW+2)'(rt);
  assign xs     = (CoordW+2)'(px_q);
  assign ys     = (CoordW+2)'(py_q);
  assign xr     = ls + $signed({2'b00, rw});
  assign yb     = ts + $signed({2'b00, rh});
  assign inside_pt = (xs >= ls) && (ys >= ts) && (xs < xr) && (ys < yb);

  always_comb begin
    unique case (kind_q)
      K_FIND_CMD: hit = (rk_id == cid_q);
      K_FIND_FOC: hit = (rk_id == fid_q);
      K_TOPVIS:   hit = rk_vis;
      K_POINT:    hit = rk_vis && inside_pt;
      K_CAND:     hit = rk_vis && !(fv_q && (rk_id == fid_q));
      default:    hit = 1'b0;
    endcase
  end

  assign cnt_m1    = AW'(count_q - 1'b1);
  assign fx_bad    = (idx_q >= count_q);
  assign fx_reject = !rk_vis || (fv_q && (fid_q == rk_id) && (idx_q == CW'(count_q - 1'b1)));
  assign ptr_nx    = (CW+1)'(ptr_q) + 1'b1;
  assign sh_more   = ptr_nx < (CW+1)'(count_q);
  assign refocus_rm = fv_q && (fid_q == cid_q);
  assign refocus_sv = !vis_q && fv_q && (fid_q == cid_q);

  assign ptr_step = up_q ? ((ptr_q == cnt_m1) ? '0 : ptr_q + 1'b1)
                         : ((ptr_q == '0) ? cnt_m1 : ptr_q - 1'b1);

  assign a_src    = (state_q == S_SCAN_EV) ? CW'(ptr_q) : count_q;
  assign cand_fwd = (state_q == S_IDLE) ? (in_mode == MODE_NEXT) : (mode_q == MODE_NEXT);
  always_comb begin
    if (a_src == count_q) begin
      cand_ptr = cand_fwd ? '0 : cnt_m1;
    end else if (cand_fwd) begin
      cand_ptr = (AW'(a_src) == cnt_m1) ? '0 : AW'(a_src) + 1'b1;
    end else begin
      cand_ptr = (AW'(a_src) == '0) ? cnt_m1 : AW'(a_src) - 1'b1;
    end
  end

  always_comb begin
    unique case (state_q)
      S_SCAN_RD: raddr = ptr_q;
      S_FX_RD:   raddr = AW'(idx_q);
      S_SH_RD:   raddr = AW'(ptr_nx);
      default:   raddr = ptr_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_ADD, MODE_QUERY: state_d = S_RESP;
            MODE_NEXT, MODE_PREV:
              state_d = (count_q < CW'(MinCycle)) ? S_RESP : S_SCAN_RD;
            default: state_d = S_SCAN_RD;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (left_q == '0) begin
          unique case (kind_q)
            K_FIND_FOC: state_d = S_SCAN_RD;
            K_CAND:     state_d = S_FX_RD;
            default:    state_d = S_RESP;
          endcase
        end else begin
          state_d = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        if (!hit) begin
          state_d = S_SCAN_RD;
        end else begin
          unique case (kind_q)
            K_FIND_CMD: begin
              priority case (mode_q)
                MODE_REMOVE: state_d = S_SH_RD;
                MODE_SETVIS: state_d = refocus_sv ? S_SCAN_RD : S_RESP;
                default:     state_d = S_FX_RD;
              endcase
            end
            K_FIND_FOC: state_d = S_SCAN_RD;
            K_TOPVIS:   state_d = S_RESP;
            default:    state_d = S_FX_RD;
          endcase
        end
      end
      S_FX_RD: state_d = fx_bad ? S_RESP : S_FX_EV;
      S_FX_EV: state_d = fx_reject ? S_RESP : S_SH_RD;
      S_SH_RD: begin
        if (sh_more) begin
          state_d = S_SH_WR;
        end else if (mode_q == MODE_REMOVE) begin
          state_d = refocus_rm ? S_SCAN_RD : S_RESP;
        end else begin
          state_d = S_HOLD_WR;
        end
      end
      S_SH_WR:   state_d = S_SH_RD;
      S_HOLD_WR: state_d = S_RESP;
      S_RESP:    state_d = resp_ready_i ? S_IDLE : S_RESP;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    kind_d  = kind_q;
    mode_d  = mode_q;
    cid_d   = cid_q;
    vis_d   = vis_q;
    px_d    = px_q;
    py_d    = py_q;
    count_d = count_q;
    fv_d    = fv_q;
    fid_d   = fid_q;
    ptr_d   = ptr_q;
    left_d  = left_q;
    idx_d   = idx_q;
    a_d     = a_q;
    up_d    = up_q;
    hold_d  = hold_q;
    ok_d    = ok_q;
    we      = 1'b0;
    waddr   = ptr_q;
    wdata   = rdata;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d = in_mode;
          cid_d  = in_id;
          vis_d  = visible_i;
          px_d   = $signed(pos_x_i);
          py_d   = $signed(pos_y_i);
          ok_d   = 1'b0;
          unique case (in_mode)
            MODE_ADD: begin
              if (width_i != '0 && height_i != '0) begin
                if (!normal_class_i) begin
                  ok_d = 1'b1;
                end else if (count_q < CW'(CAPACITY)) begin
                  we      = 1'b1;
                  waddr   = AW'(count_q);
                  wdata   = {height_i, width_i, pos_y_i, pos_x_i, 1'b1, in_id};
                  count_d = count_q + 1'b1;
                  fv_d    = 1'b1;
                  fid_d   = in_id;
                  ok_d    = 1'b1;
                end
              end
            end
            MODE_REMOVE, MODE_SETVIS, MODE_FOCUS_ID: begin
              kind_d = K_FIND_CMD;
              ptr_d  = '0;
              left_d = count_q;
              up_d   = 1'b1;
            end
            MODE_POINT: begin
              kind_d = K_POINT;
              ptr_d  = cnt_m1;
              left_d = count_q;
              up_d   = 1'b0;
            end
            MODE_NEXT, MODE_PREV: begin
              left_d = count_q;
              if (fv_q) begin
                kind_d = K_FIND_FOC;
                ptr_d  = '0;
                up_d   = 1'b1;
              end else begin
                kind_d = K_CAND;
                a_d    = a_src;
                ptr_d  = cand_ptr;
                up_d   = cand_fwd;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (left_q == '0) begin
          if (kind_q == K_FIND_FOC) begin
            kind_d = K_CAND;
            a_d    = a_src;
            ptr_d  = cand_ptr;
            left_d = count_q;
            up_d   = cand_fwd;
          end else if (kind_q == K_CAND) begin
            idx_d = a_q;
          end
        end
      end
      S_SCAN_EV: begin
        left_d = left_q - 1'b1;
        ptr_d  = ptr_step;
        if (hit) begin
          idx_d = CW'(ptr_q);
          unique case (kind_q)
            K_FIND_CMD: begin
              if (mode_q == MODE_REMOVE) begin
                ok_d  = 1'b1;
                ptr_d = ptr_q;
              end else if (mode_q == MODE_SETVIS) begin
                we    = 1'b1;
                waddr = ptr_q;
                wdata = {rdata[EW-1:KW], vis_q, rdata[ID_BITS-1:0]};
                if (refocus_sv) begin
                  kind_d = K_TOPVIS;
                  up_d   = 1'b0;
                  left_d = count_q;
                  ptr_d  = cnt_m1;
                  fv_d   = 1'b0;
                  fid_d  = '0;
                end
              end
            end
            K_FIND_FOC: begin
              kind_d = K_CAND;
              a_d    = a_src;
              ptr_d  = cand_ptr;
              left_d = count_q;
              up_d   = cand_fwd;
            end
            K_TOPVIS: begin
              fv_d  = 1'b1;
              fid_d = rk_id;
            end
            default: ;
          endcase
        end
      end
      S_FX_EV: begin
        if (!fx_reject) begin
          hold_d = rdata;
          fv_d   = 1'b1;
          fid_d  = rk_id;
          ok_d   = 1'b1;
          ptr_d  = AW'(idx_q);
        end
      end
      S_SH_RD: begin
        if (!sh_more && mode_q == MODE_REMOVE) begin
          count_d = count_q - 1'b1;
          if (refocus_rm) begin
            kind_d = K_TOPVIS;
            up_d   = 1'b0;
            left_d = count_q - 1'b1;
            ptr_d  = AW'(count_q - CW'(2));
            fv_d   = 1'b0;
            fid_d  = '0;
          end
        end
      end
      S_SH_WR: begin
        we    = 1'b1;
        waddr = ptr_q;
        wdata = rdata;
        ptr_d = ptr_q + 1'b1;
      end
      S_HOLD_WR: begin
        we    = 1'b1;
        waddr = cnt_m1;
        wdata = hold_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      fv_q    <= 1'b0;
      fid_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      fv_q    <= fv_d;
      fid_q   <= fid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    mode_q <= mode_d;
    cid_q  <= cid_d;
    vis_q  <= vis_d;
    px_q   <= px_d;
    py_q   <= py_d;
    ptr_q  <= ptr_d;
    left_q <= left_d;
    idx_q  <= idx_d;
    a_q    <= a_d;
    up_q   <= up_d;
    hold_q <= hold_d;
    ok_q   <= ok_d;
  end

  assign in_stall_o          = (state_q != S_IDLE);
  assign resp_valid_o        = (state_q == S_RESP);
  assign resp_o.ok           = ok_q;
  assign resp_o.active_valid = fv_q;
  assign resp_o.active_id    = 8'(fid_q);
  assign resp_o.window_count = 7'(count_q);

endmodule

[rtl/window_zorder_focus_stack.sv]
// Window z-order and focus stack.
// Input channel: one request per command (mode, window_id, normal_class,
// visible, pos_x, pos_y, width, height), taken when in_valid_i is high and
// in_stall_o is low. Output channel: one result per request (ok,
// active_valid, active_id, window_count), taken when out_valid_o is high
// and out_stall_i is low.
// The stack lives in one synchronous memory with a registered read; every
// stack search visits each entry in a read state, then an evaluate state.
// Remove, visibility and focus by id search the stack; remove and focus by
// id then shift entries, and removing or hiding the focused window adds a
// refocus walk. Focus by point searches from the top. Next and previous
// locate the focus, walk the candidates, then shift. The block handles one
// request at a time and takes the next request while the previous result
// still waits in the output register.
// Reset empties the stack and clears the focus; no memory sweep is needed.
// A stalled result holds in the output register; the block then finishes
// at most one more request and holds its result until the register frees.
module window_zorder_focus_stack
  import wzfs_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef,
  parameter int unsigned ID_BITS  = IdBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  window_id_i,
  input  logic        normal_class_i,
  input  logic        visible_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] width_i,
  input  logic [15:0] height_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic        active_valid_o,
  output logic [7:0]  active_id_o,
  output logic [6:0]  window_count_o
);

  logic  resp_valid, resp_ready, out_valid_q;
  resp_t resp, out_q;

  wzfs_ctrl #(.CAPACITY(CAPACITY), .ID_BITS(ID_BITS)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .window_id_i    (window_id_i),
    .normal_class_i (normal_class_i),
    .visible_i      (visible_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .width_i        (width_i),
    .height_i       (height_i),
    .resp_valid_o   (resp_valid),
    .resp_ready_i   (resp_ready),
    .resp_o         (resp)
  );

  assign resp_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_ready) begin
      out_valid_q <= resp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_ready && resp_valid) begin
      out_q <= resp;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = out_q.ok;
  assign active_valid_o = out_q.active_valid;
  assign active_id_o    = out_q.active_id;
  assign window_count_o = out_q.window_count;

  a_no_focus_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !active_valid_o |-> active_id_o == 8'd0)
    else $error("active id set without focus");

  a_focus_needs_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && active_valid_o |-> window_count_o != 7'd0 || CAPACITY >= 128)
    else $error("focus held on an empty stack");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

endmodule

[bench/tb_window_zorder_focus_stack.sv]
module tb_window_zorder_focus_stack;
  import wzfs_pkg::*;

  localparam int unsigned Depth = 64;
  localparam int unsigned CycleLimit = 8000000;

  typedef struct packed {
    logic       ok;
    logic       act_valid;
    logic [7:0] act_id;
    logic [6:0] count;
  } outcome_t;

  typedef struct {
    logic [7:0]  id;
    logic        vis;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
  } win_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  mode_i;
  logic [7:0]  window_id_i;
  logic        normal_class_i;
  logic        visible_i;
  logic [15:0] pos_x_i;
  logic [15:0] pos_y_i;
  logic [15:0] width_i;
  logic [15:0] height_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        ok_o;
  logic        active_valid_o;
  logic [7:0]  active_id_o;
  logic [6:0]  window_count_o;

  win_t     zstack[Depth];
  int       zdepth;
  logic     has_focus;
  logic [7:0] focused_id;
  outcome_t pending_q[$];
  int       mismatches;
  int       cycles;
  bit       burst_on;
  int       stall_phase;

  window_zorder_focus_stack i_dut (.*);

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    stall_phase <= stall_phase + 1;
    case ((stall_phase >> 9) % 3)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ((stall_phase % 7) < 4);
    endcase
  end

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        want = pending_q.pop_front();
        if (want !== {ok_o, active_valid_o, active_id_o, window_count_o}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp ok=%0d av=%0d id=%0d n=%0d got ok=%0d av=%0d id=%0d n=%0d",
                     want.ok, want.act_valid, want.act_id, want.count,
                     ok_o, active_valid_o, active_id_o, window_count_o);
        end
      end
    end
  end

  function automatic int find_window(logic [7:0] id);
    for (int i = 0; i < zdepth; i++)
      if (zstack[i].id == id) return i;
    return zdepth;
  endfunction

  function automatic void refocus_topmost();
    has_focus = 1'b0;
    focused_id = '0;
    for (int i = zdepth - 1; i >= 0; i--)
      if (zstack[i].vis) begin
        has_focus = 1'b1;
        focused_id = zstack[i].id;
        return;
      end
  endfunction

  function automatic void drop_at(int idx);
    for (int i = idx; i + 1 < zdepth; i++) zstack[i] = zstack[i + 1];
    zdepth--;
  endfunction

  function automatic logic raise_window(int idx);
    win_t picked;
    if (idx >= zdepth || !zstack[idx].vis) return 1'b0;
    if (has_focus && focused_id == zstack[idx].id && idx + 1 == zdepth) return 1'b0;
    picked = zstack[idx];
    for (int i = idx; i + 1 < zdepth; i++) zstack[i] = zstack[i + 1];
    zstack[zdepth - 1] = picked;
    has_focus = 1'b1;
    focused_id = picked.id;
    return 1'b1;
  endfunction

  function automatic outcome_t apply_command(mode_e md, logic [7:0] id, logic normal,
                                             logic vis, logic [15:0] px, logic [15:0] py,
                                             logic [15:0] w, logic [15:0] h);
    outcome_t res;
    logic ok;
    int idx, a, c, n;
    int signed l, t, x, y;
    ok = 1'b0;
    n = zdepth;
    case (md)
      MODE_ADD: begin
        if (w == 0 || h == 0) ok = 1'b0;
        else if (!normal) ok = 1'b1;
        else if (n < Depth) begin
          zstack[n] = '{id, 1'b1, px, py, w, h};
          zdepth = n + 1;
          has_focus = 1'b1;
          focused_id = id;
          ok = 1'b1;
        end
      end
      MODE_REMOVE: begin
        idx = find_window(id);
        if (idx < n) begin
          drop_at(idx);
          if (has_focus && focused_id == id) refocus_topmost();
          ok = 1'b1;
        end
      end
      MODE_SETVIS: begin
        idx = find_window(id);
        if (idx < n) begin
          zstack[idx].vis = vis;
          if (!vis && has_focus && focused_id == id) refocus_topmost();
        end
      end
      MODE_FOCUS_ID: ok = raise_window(find_window(id));
      MODE_POINT: begin
        x = $signed(px);
        y = $signed(py);
        idx = n;
        for (int i = n - 1; i >= 0; i--) begin
          l = $signed(zstack[i].x);
          t = $signed(zstack[i].y);
          if (zstack[i].vis && x >= l && y >= t && x < l + int'(zstack[i].w)
              && y < t + int'(zstack[i].h)) begin
            idx = i;
            break;
          end
        end
        ok = raise_window(idx);
      end
      MODE_NEXT, MODE_PREV: begin
        if (n >= 2) begin
          a = has_focus ? find_window(focused_id) : n;
          idx = a;
          for (int s = 1; s <= n; s++) begin
            if (md == MODE_NEXT) c = (a == n) ? s - 1 : (a + s) % n;
            else c = (a == n) ? n - s : (a + n - (s % n)) % n;
            if (zstack[c].vis && !(has_focus && zstack[c].id == focused_id)) begin
              idx = c;
              break;
            end
          end
          ok = raise_window(idx);
        end
      end
      default: ;
    endcase
    if (!has_focus) focused_id = '0;
    res.ok = ok;
    res.act_valid = has_focus;
    res.act_id = focused_id;
    res.count = 7'(zdepth);
    return res;
  endfunction

  task automatic send_command(mode_e md, logic [7:0] id, logic normal, logic vis,
                              logic [15:0] px, logic [15:0] py,
                              logic [15:0] w, logic [15:0] h);
    if (!burst_on) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_on = 1'b1;
    end
    in_valid_i <= 1'b1;
    mode_i <= md;
    window_id_i <= id;
    normal_class_i <= normal;
    visible_i <= vis;
    pos_x_i <= px;
    pos_y_i <= py;
    width_i <= w;
    height_i <= h;
    do @(posedge clk_i); while (in_stall_o);
    pending_q.push_back(apply_command(md, id, normal, vis, px, py, w, h));
    @(negedge clk_i);
    if ($urandom_range(0, 9) == 0) burst_on = 1'b0;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_id();
    if (zdepth > 0 && $urandom_range(0, 3) != 0)
      return zstack[$urandom_range(0, zdepth - 1)].id;
    return 8'($urandom);
  endfunction

  task automatic test_directed();
    send_command(MODE_QUERY, 8'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_command(MODE_NEXT, 8'd0, 1'b1, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0);
    send_command(MODE_ADD, 8'd1, 1'b1, 1'b1, 16'h0, 16'h0, 16'h0, 16'd5);
    send_command(MODE_ADD, 8'd2, 1'b0, 1'b1, 16'h0, 16'h0, 16'd5, 16'd5);
    send_command(MODE_ADD, 8'hff, 1'b1, 1'b0, 16'h8000, 16'h8000, 16'hffff, 16'hffff);
    send_command(MODE_ADD, 8'h00, 1'b1, 1'b0, 16'h7fff, 16'h7fff, 16'd1, 16'd1);
    send_command(MODE_ADD, 8'h10, 1'b1, 1'b0, 16'd0, 16'd0, 16'd10, 16'd10);
    send_command(MODE_POINT, 8'd0, 1'b0, 1'b0, 16'd10, 16'd5, 16'h0, 16'h0);
    send_command(MODE_POINT, 8'd0, 1'b0, 1'b0, 16'd9, 16'd9, 16'h0, 16'h0);
    send_command(MODE_POINT, 8'd0, 1'b0, 1'b0, 16'h7fff, 16'h7fff, 16'h0, 16'h0);
    send_command(MODE_POINT, 8'd0, 1'b0, 1'b0, 16'h7fff, 16'h7ffe, 16'h0, 16'h0);
    send_command(MODE_FOCUS_ID, 8'h00, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_command(MODE_FOCUS_ID, 8'h00, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_command(MODE_SETVIS, 8'h00, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_command(MODE_FOCUS_ID, 8'h00, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_command(MODE_SETVIS, 8'h00, 1'b0, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0);
    send_command(MODE_SETVIS, 8'h77, 1'b0, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0);
    send_command(MODE_NEXT, 8'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_command(MODE_PREV, 8'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_command(MODE_REMOVE, 8'h55, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_command(MODE_REMOVE, focused_id, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_command(MODE_REMOVE, 8'hff, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_command(MODE_REMOVE, 8'h00, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_command(MODE_PREV, 8'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
  endtask

  task automatic test_full_stack();
    drain_results();
    for (int i = 0; i < Depth + 2; i++)
      send_command(MODE_ADD, 8'(8'h40 + i), 1'b1, 1'b0, 16'($urandom), 16'($urandom),
                   16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
    send_command(MODE_SETVIS, zstack[Depth - 1].id, 1'b0, 1'b0,
                 16'h0, 16'h0, 16'h0, 16'h0);
    send_command(MODE_PREV, 8'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    while (zdepth > 0)
      send_command(MODE_REMOVE, zstack[$urandom_range(0, zdepth - 1)].id, 1'b0, 1'b0,
                   16'h0, 16'h0, 16'h0, 16'h0);
  endtask

  task automatic test_random(int count);
    mode_e md;
    logic [7:0] id;
    logic [15:0] px, py;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (zdepth < 6 && r < 40) md = MODE_ADD;
      else if (zdepth > 20 && r < 30) md = MODE_REMOVE;
      else md = mode_e'($urandom_range(0, 7));
      if (md == MODE_ADD) begin
        id = 8'($urandom);
        while (find_window(id) < zdepth) id = 8'($urandom);
      end else id = pick_id();
      px = 16'($urandom_range(0, 400) - 200);
      py = 16'($urandom_range(0, 400) - 200);
      if ($urandom_range(0, 7) == 0) begin
        px = 16'($urandom);
        py = 16'($urandom);
      end
      send_command(md, id, $urandom_range(0, 5) != 0, 1'($urandom), px, py,
                   16'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 300)),
                   16'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 300)));
      if (k == count / 2) drain_results();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    mode_i = MODE_QUERY;
    window_id_i = '0;
    normal_class_i = 1'b0;
    visible_i = 1'b0;
    pos_x_i = '0;
    pos_y_i = '0;
    width_i = '0;
    height_i = '0;
    zdepth = 0;
    has_focus = 1'b0;
    focused_id = '0;
    mismatches = 0;
    cycles = 0;
    stall_phase = 0;
    burst_on = 1'b1;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_full_stack();
    test_random(1650);
    drain_results();
    repeat (1000) @(negedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[window_zorder_focus_stack.f]
rtl/wzfs_pkg.sv
rtl/wzfs_mem.sv
rtl/wzfs_ctrl.sv
rtl/window_zorder_focus_stack.sv
bench/tb_window_zorder_focus_stack.sv
